>>> design/sard_pkg.sv
// Shared constants and types for the sort-and-remove-duplicates block.
// Used by sard_cell, sard_chain and the top level; depends on nothing.
package sard_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = $clog2(MAX_ITEMS + 1);

  // Control broadcast to every cell of the sorting chain.
  typedef struct packed {
    logic                      insert;
    logic                      shift;
    logic signed [VALUE_W-1:0] value;
  } cell_ctl_t;

endpackage

>>> design/sard_cell.sv
// One cell of the insertion-sorting chain: holds a single value and a valid flag.
// Depends on sard_pkg.
module sard_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  sard_pkg::cell_ctl_t                ctl,
  input  logic                               prev_takes,
  input  logic                               prev_valid,
  input  logic signed [sard_pkg::VALUE_W-1:0] prev_value,
  input  logic                               next_valid,
  input  logic signed [sard_pkg::VALUE_W-1:0] next_value,
  output logic                               takes,
  output logic                               valid,
  output logic signed [sard_pkg::VALUE_W-1:0] value
);

  // An empty cell, or one holding a larger value, makes room for the new one.
  assign takes = !valid || (ctl.value < value);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.insert && takes) begin
      valid <= prev_takes ? prev_valid : 1'b1;
    end else if (ctl.shift) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.insert && takes) begin
      value <= prev_takes ? prev_value : ctl.value;
    end else if (ctl.shift) begin
      value <= next_value;
    end
  end

endmodule

>>> design/sard_chain.sv
// Row of sorting cells kept in ascending order; the head is cell zero.
// Depends on sard_pkg and sard_cell.
module sard_chain (
  input  logic                                clk,
  input  logic                                rst,
  input  sard_pkg::cell_ctl_t                 ctl,
  output logic                                head_valid,
  output logic signed [sard_pkg::VALUE_W-1:0] head_value
);

  localparam int N = sard_pkg::MAX_ITEMS;

  logic                               takes [N];
  logic                               valid [N];
  logic signed [sard_pkg::VALUE_W-1:0] value [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                               p_takes;
    logic                               p_valid;
    logic signed [sard_pkg::VALUE_W-1:0] p_value;
    logic                               n_valid;
    logic signed [sard_pkg::VALUE_W-1:0] n_value;

    if (i == 0) begin : g_first
      assign p_takes = 1'b0;
      assign p_valid = 1'b0;
      assign p_value = '0;
    end else begin : g_inner
      assign p_takes = takes[i-1];
      assign p_valid = valid[i-1];
      assign p_value = value[i-1];
    end

    if (i == N - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_value = '0;
    end else begin : g_body
      assign n_valid = valid[i+1];
      assign n_value = value[i+1];
    end

    sard_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_takes (p_takes),
      .prev_valid (p_valid),
      .prev_value (p_value),
      .next_valid (n_valid),
      .next_value (n_value),
      .takes      (takes[i]),
      .valid      (valid[i]),
      .value      (value[i])
    );
  end

  assign head_valid = valid[0];
  assign head_value = value[0];

endmodule

>>> design/sort_and_remove_duplicates_top.sv
// Top level of the sort-and-remove-duplicates block: load control, drain and
// duplicate removal. Depends on sard_pkg and sard_chain.
//
// Usage
// -----
// Values of a block arrive on the command channel: a transfer happens at a
// rising edge where start is high and busy is low, carrying value and last.
// While loading, busy stays low, so one value can be taken in every cycle;
// each value is inserted into a row of MAX_ITEMS cells that keeps the block
// in ascending signed order. Values beyond MAX_ITEMS are dropped and the
// block's overflow flag is set.
// The transfer with last high closes the block. busy then rises and the row
// shifts towards its head one cell per cycle. Equal neighbours are merged,
// and each distinct value is shown on result_value for exactly one cycle,
// marked by result_valid; end_of_block marks the final one and overflow is
// repeated on every result of the block. The drain runs until the shift has
// emptied the cell row, and the final result appears in the same cycle in
// which busy falls. The receiver cannot stall the results. A synchronous
// reset empties the row and returns to loading.
module sort_and_remove_duplicates_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [sard_pkg::VALUE_W-1:0] value,
  input  logic                                last,
  output logic                                result_valid,
  output logic signed [sard_pkg::VALUE_W-1:0] result_value,
  output logic                                end_of_block,
  output logic                                overflow
);

  typedef enum logic {
    S_LOAD,
    S_DRAIN
  } state_t;

  state_t                              state;
  logic [sard_pkg::COUNT_W-1:0]        count;
  logic                                overflow_seen;
  logic                                have_pending;
  logic signed [sard_pkg::VALUE_W-1:0] pending;

  logic                                accept;
  logic                                full;
  sard_pkg::cell_ctl_t                 ctl;
  logic                                head_valid;
  logic signed [sard_pkg::VALUE_W-1:0] head_value;

  assign busy   = (state == S_DRAIN);
  assign accept = start && !busy;
  assign full   = (count == sard_pkg::COUNT_W'(sard_pkg::MAX_ITEMS));

  // Insert while loading and not full; shift the row towards the head while
  // draining and the head still holds a value.
  always_comb begin
    ctl.insert = accept && !full;
    ctl.shift  = (state == S_DRAIN) && head_valid;
    ctl.value  = value;
  end

  sard_chain u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .head_valid (head_valid),
    .head_value (head_value)
  );

  // Control and result registers. A value leaving the head is held back as
  // pending until the next different value shows that it was not the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      count         <= '0;
      overflow_seen <= 1'b0;
      have_pending  <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (full) begin
              overflow_seen <= 1'b1;
            end else begin
              count <= count + 1'b1;
            end
            if (last) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (head_valid) begin
            if (have_pending && (head_value != pending)) begin
              result_valid <= 1'b1;
              result_value <= pending;
              end_of_block <= 1'b0;
              overflow     <= overflow_seen;
            end
            pending      <= head_value;
            have_pending <= 1'b1;
          end else begin
            // Row empty: the pending value is the block's final result.
            result_valid  <= 1'b1;
            result_value  <= pending;
            end_of_block  <= 1'b1;
            overflow      <= overflow_seen;
            have_pending  <= 1'b0;
            count         <= '0;
            overflow_seen <= 1'b0;
            state         <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

>>> design/sard_checker.sv
// Port-level checks for sort_and_remove_duplicates_top, attached by bind.
// Depends on sard_pkg and the top level's ports.
module sard_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                last,
  input logic                                result_valid,
  input logic signed [sard_pkg::VALUE_W-1:0] result_value,
  input logic                                end_of_block,
  input logic                                overflow
);

  // Closing a block always starts the drain.
  a_last_starts_drain: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last) |=> busy)
    else $error("block close did not start the drain");

  // Only the final result of a block is shown once the drain has finished.
  a_final_when_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && end_of_block) |-> !busy)
    else $error("final result shown while still draining");

  a_inner_while_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !end_of_block) |-> busy)
    else $error("non-final result shown outside the drain");

  // The first head value is only held back, never shown at once.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |=> !result_valid)
    else $error("result shown before any comparison was possible");

  // Every result transfer carries fully defined fields.
  a_result_known: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !$isunknown({result_value, end_of_block, overflow}))
    else $error("result transfer with undefined fields");

endmodule

bind sort_and_remove_duplicates_top sard_checker u_sard_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .last         (last),
  .result_valid (result_valid),
  .result_value (result_value),
  .end_of_block (end_of_block),
  .overflow     (overflow)
);
